// ===== design/assert_macros.svh =====
// Assertion macros used by the csv field splitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/csvfs_pkg.sv =====
// Package: characters, parse modes and state/result types of the csv field splitter.
`timescale 1ns / 1ps
package csvfs_pkg;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [3:0] {
    MODE_START  = 4'b0001,
    MODE_QUOTED = 4'b0010,
    MODE_CLOSED = 4'b0100,
    MODE_PLAIN  = 4'b1000
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  esc_pending;
    logic  after_cr;
    logic  nonempty;
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       field_end;
    logic       line_end;
  } result_t;

  localparam state_t RESET_STATE = '{mode: MODE_START, esc_pending: 1'b0,
                                     after_cr: 1'b0, nonempty: 1'b0};

endpackage

// ===== design/csvfs_if.sv =====
// Stream interfaces for the text input and the field result output.
`timescale 1ns / 1ps
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       field_end;
  logic       line_end;

  modport source (output valid, output data_byte, output has_byte, output field_end,
                  output line_end, input ready);
  modport sink   (input valid, input data_byte, input has_byte, input field_end,
                  input line_end, output ready);
endinterface

// ===== design/csvfs_step.sv =====
// Next-state and result logic for one text byte.
`timescale 1ns / 1ps
module csvfs_step import csvfs_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] byte_i,
  input  logic       eoi_i,
  output state_t     state_o,
  output result_t    res_o,
  output logic       res_valid_o
);

  logic   is_brk;
  logic   swallow;
  logic   has, fe, le;
  state_t nxt;

  always_comb begin
    is_brk  = byte_i inside {CH_CR, CH_LF};
    swallow = state_i.after_cr && (byte_i == CH_LF);
    has     = 1'b0;
    fe      = 1'b0;
    le      = 1'b0;
    nxt          = state_i;
    nxt.after_cr = 1'b0;

    if (!swallow) begin
      if (state_i.esc_pending) begin
        nxt.esc_pending = 1'b0;
        has             = 1'b1;
      end else begin
        case (state_i.mode)
          MODE_START: begin
            if (is_brk) begin
              le = 1'b1;
            end else if (byte_i == CH_BSLASH) begin
              nxt.esc_pending = 1'b1;
              nxt.mode        = MODE_PLAIN;
            end else if (byte_i == CH_COMMA) begin
              fe = 1'b1;
            end else if (byte_i == CH_QUOTE) begin
              nxt.mode = MODE_QUOTED;
            end else begin
              has      = 1'b1;
              nxt.mode = MODE_PLAIN;
            end
          end
          MODE_QUOTED: begin
            if (byte_i == CH_BSLASH) begin
              nxt.esc_pending = 1'b1;
            end else if (byte_i == CH_QUOTE) begin
              fe       = 1'b1;
              nxt.mode = MODE_CLOSED;
            end else begin
              has = 1'b1;
            end
          end
          MODE_CLOSED: begin
            if (byte_i == CH_COMMA) begin
              nxt.mode = MODE_START;
            end else if (is_brk) begin
              le = 1'b1;
            end
          end
          MODE_PLAIN: begin
            if (is_brk) begin
              fe = 1'b1;
              le = 1'b1;
            end else if (byte_i == CH_BSLASH) begin
              nxt.esc_pending = 1'b1;
            end else if (byte_i == CH_COMMA) begin
              fe       = 1'b1;
              nxt.mode = MODE_START;
            end else begin
              has = 1'b1;
            end
          end
          default: begin
            nxt.mode = MODE_START;
          end
        endcase
      end
      if (has) nxt.nonempty = 1'b1;
      if (fe)  nxt.nonempty = 1'b0;
      if (le) begin
        nxt.mode        = MODE_START;
        nxt.esc_pending = 1'b0;
        nxt.nonempty    = 1'b0;
        nxt.after_cr    = (byte_i == CH_CR);
      end
    end

    // end of text: flush a non-empty open field, close the line, back to reset
    if (eoi_i) begin
      if (!le) begin
        fe = fe | nxt.nonempty;
        le = 1'b1;
      end
      nxt = RESET_STATE;
    end

    state_o           = nxt;
    res_o.data_byte   = has ? byte_i : 8'h00;
    res_o.has_byte    = has;
    res_o.field_end   = fe;
    res_o.line_end    = le;
    res_valid_o       = has | fe | le;
  end

endmodule

// ===== design/csv_field_splitter.sv =====
// Top level of the csv field splitter: state register, result register, handshakes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Splits CSV text, one byte per input word, into field bytes, field ends and
// line ends. Fields are unquoted or double-quoted; a backslash passes the next
// byte through literally; bytes after a closing quote are ignored up to the
// next comma or line break; a trailing empty field is dropped; an LF right
// after a CR that ended a line is swallowed. end_of_input on a byte flushes a
// non-empty open field, closes the line and returns the parser to reset.
// Each accepted byte yields zero or one result word. Throughput is one byte
// per clock: the parse state is a small register updated in the same cycle a
// byte is accepted, and the result sits in an output register, so a byte is
// taken whenever that register is empty or being drained. A result is valid in
// the cycle after its byte is accepted. No clearing pass after reset.
module csv_field_splitter import csvfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  csvfs_in_if.sink     in_i,
  csvfs_out_if.source  out_o
);

  state_t  state_q, state_d;
  result_t out_q, res_d;
  logic    out_valid_q;
  logic    res_valid_d;
  logic    in_accept;

  // Take a byte whenever the result register is free or drains this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  csvfs_step u_step (
    .state_i     (state_q),
    .byte_i      (in_i.in_byte),
    .eoi_i       (in_i.end_of_input),
    .state_o     (state_d),
    .res_o       (res_d),
    .res_valid_o (res_valid_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= RESET_STATE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q     <= state_d;
        out_valid_q <= res_valid_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: loaded on every accept that produces a word.
  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid_d) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.data_byte = out_q.data_byte;
  assign out_o.has_byte  = out_q.has_byte;
  assign out_o.field_end = out_q.field_end;
  assign out_o.line_end  = out_q.line_end;

  // End of text always produces a line end in the next result word.
  `ASSERT_NEXT(a_eoi_closes_line, clk_i, rst_ni, in_accept && in_i.end_of_input,
               out_valid_q && out_q.line_end)
  // ... and leaves the parser in its reset state.
  `ASSERT_NEXT(a_eoi_resets_state, clk_i, rst_ni, in_accept && in_i.end_of_input,
               state_q == RESET_STATE)
  // A result word never carries nothing, and data is zero without a byte.
  `ASSERT_AT(a_word_nonempty, clk_i, rst_ni,
             !out_valid_q || ((out_q.has_byte || out_q.field_end || out_q.line_end) &&
                              (out_q.has_byte || out_q.data_byte == 8'h00)))

endmodule

// ===== dv/csv_field_splitter_tb.sv =====
// Testbench for csv_field_splitter: CSV byte stimulus, scoreboard against a behavioral predictor.
`timescale 1ns / 1ps
module csv_field_splitter_tb import csvfs_pkg::*;;

  // Cycles without any accepted word, on either side, before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 2000;
  // Random idling: chance, in percent, that a side idles when it could act.
  localparam int unsigned IDLE_PCT    = 36;
  // Window of sent bytes in which neither side idles.
  localparam int unsigned CALM_FROM   = 300;
  localparam int unsigned CALM_TO     = 420;
  // Receiver hold-off: starts after this many results, lasts this many cycles.
  localparam int unsigned HOLD_AT     = 120;
  localparam int unsigned HOLD_LEN    = 80;
  localparam int unsigned RANDOM_BYTES = 620;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } text_word_t;

  logic clk = 1'b0;
  logic rst_n;

  csvfs_in_if  in_if ();
  csvfs_out_if out_if ();

  csv_field_splitter u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk = ~clk;

  // Bytes still to be offered; the front one is on the bus while valid is high.
  text_word_t  text_bytes[$];
  // Results the splitter owes us, oldest first.
  result_t     due_words[$];
  // Predictor copy of the parser state.
  state_t      split_st;

  int unsigned n_bytes_sent;
  int unsigned n_words_seen;
  int unsigned n_field_ends;
  int unsigned n_line_ends;
  int unsigned n_data_bytes;
  int unsigned n_errors;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  bit          hold_done;
  logic        calm;

  assign calm = (n_bytes_sent >= CALM_FROM) && (n_bytes_sent < CALM_TO);

  // ---------------------------------------------------------------------------
  // Predictor: advance split_st by one text byte; returns 1 when the byte
  // yields a result word, which is written to res.
  // ---------------------------------------------------------------------------
  function automatic bit split_byte(input logic [7:0] b, input logic eoi,
                                    output result_t res);
    logic is_brk;
    logic swallow;
    logic has;
    logic fe;
    logic le;
    is_brk  = (b == CH_CR) || (b == CH_LF);
    swallow = 1'b0;
    has     = 1'b0;
    fe      = 1'b0;
    le      = 1'b0;

    // LF right after a CR that ended a line is dropped without a trace
    if (split_st.after_cr) begin
      split_st.after_cr = 1'b0;
      if (b == CH_LF) swallow = 1'b1;
    end

    if (!swallow) begin
      if (split_st.esc_pending) begin
        // escaped byte goes into the field whatever it is
        split_st.esc_pending = 1'b0;
        has = 1'b1;
      end else begin
        case (split_st.mode)
          MODE_START: begin
            if (is_brk) begin
              le = 1'b1;                 // trailing empty field dropped
            end else if (b == CH_BSLASH) begin
              split_st.esc_pending = 1'b1;
              split_st.mode        = MODE_PLAIN;
            end else if (b == CH_COMMA) begin
              fe = 1'b1;
            end else if (b == CH_QUOTE) begin
              split_st.mode = MODE_QUOTED;
            end else begin
              has           = 1'b1;
              split_st.mode = MODE_PLAIN;
            end
          end
          MODE_QUOTED: begin
            if (b == CH_BSLASH) begin
              split_st.esc_pending = 1'b1;
            end else if (b == CH_QUOTE) begin
              fe            = 1'b1;
              split_st.mode = MODE_CLOSED;
            end else begin
              has = 1'b1;
            end
          end
          MODE_CLOSED: begin
            // junk after the closing quote is ignored, backslash included
            if (b == CH_COMMA) split_st.mode = MODE_START;
            else if (is_brk) le = 1'b1;
          end
          default: begin
            // unquoted field
            if (is_brk) begin
              fe = 1'b1;
              le = 1'b1;
            end else if (b == CH_BSLASH) begin
              split_st.esc_pending = 1'b1;
            end else if (b == CH_COMMA) begin
              fe            = 1'b1;
              split_st.mode = MODE_START;
            end else begin
              has = 1'b1;
            end
          end
        endcase
      end
      if (has) split_st.nonempty = 1'b1;
      if (fe)  split_st.nonempty = 1'b0;
      if (le) begin
        split_st.mode        = MODE_START;
        split_st.esc_pending = 1'b0;
        split_st.nonempty    = 1'b0;
        split_st.after_cr    = (b == CH_CR);
      end
    end

    // end of text: flush a non-empty field, close the line once, back to reset
    if (eoi) begin
      if (!le) begin
        if (split_st.nonempty) fe = 1'b1;
        le = 1'b1;
      end
      split_st = RESET_STATE;
    end

    res.data_byte = has ? b : 8'h00;
    res.has_byte  = has;
    res.field_end = fe;
    res.line_end  = le;
    return has || fe || le;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b, input logic eoi = 1'b0);
    text_bytes.push_back('{b, eoi});
  endtask

  // any byte that carries no meaning to the parser
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {CH_COMMA, CH_QUOTE, CH_CR, CH_LF, CH_BSLASH});
    return c;
  endfunction

  task automatic add_plain_field();
    int unsigned len;
    len = $urandom_range(1, 4);
    repeat (len) begin
      if ($urandom_range(0, 99) < 15) begin
        add_byte(CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(plain_char());
      end
    end
  endtask

  task automatic add_quoted_field();
    int unsigned len;
    logic [7:0]  c;
    len = $urandom_range(0, 4);
    add_byte(CH_QUOTE);
    repeat (len) begin
      if ($urandom_range(0, 99) < 20) begin
        add_byte(CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        // commas and line breaks are plain content inside quotes
        do c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BSLASH);
        add_byte(c);
      end
    end
    // a few fields are left open so the line break lands inside quotes
    if ($urandom_range(0, 99) < 95) begin
      add_byte(CH_QUOTE);
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) begin
          do c = 8'($urandom_range(0, 255));
          while (c inside {CH_COMMA, CH_CR, CH_LF});
          add_byte(c);
        end
      end
    end
  endtask

  // One CSV line: mostly well-formed fields, some raw noise, varied terminators.
  task automatic add_random_line();
    int unsigned n_fields;
    int unsigned sel;
    n_fields = $urandom_range(1, 5);
    for (int unsigned f = 0; f < n_fields; f++) begin
      if (f != 0) add_byte(CH_COMMA);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        add_plain_field();
      end else if (sel < 85) begin
        add_quoted_field();
      end else if (sel >= 93) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
      end
      // otherwise: empty field
    end
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      add_byte(CH_LF);
    end else if (sel < 55) begin
      add_byte(CH_CR);
    end else if (sel < 85) begin
      add_byte(CH_CR);
      add_byte(CH_LF);
    end else if (sel < 93 && text_bytes.size() != 0) begin
      // text ends on the last byte of the line
      text_bytes[text_bytes.size() - 1].eoi = 1'b1;
    end else begin
      add_byte(CH_LF, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers the front byte, holds it until taken, predicts on accept.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    result_t res;
    if (!rst_n) begin
      in_if.valid        <= 1'b0;
      in_if.in_byte      <= 8'h00;
      in_if.end_of_input <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (split_byte(in_if.in_byte, in_if.end_of_input, res)) due_words.push_back(res);
        void'(text_bytes.pop_front());
        n_bytes_sent++;
      end
      if (in_if.valid && !in_if.ready) begin
        // word stays on the bus until taken
      end else if (text_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_if.valid        <= 1'b1;
        in_if.in_byte      <= text_bytes[0].ch;
        in_if.end_of_input <= text_bytes[0].eoi;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: checks each accepted word against the oldest expectation,
  // drives ready with random stalls and one long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    result_t exp_w;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_words_seen++;
        if (out_if.has_byte === 1'b1)  n_data_bytes++;
        if (out_if.field_end === 1'b1) n_field_ends++;
        if (out_if.line_end === 1'b1)  n_line_ends++;
        if (due_words.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%t: unexpected word data=%h has=%b fe=%b le=%b", $realtime,
                     out_if.data_byte, out_if.has_byte, out_if.field_end, out_if.line_end);
        end else begin
          exp_w = due_words.pop_front();
          if (out_if.data_byte !== exp_w.data_byte || out_if.has_byte !== exp_w.has_byte ||
              out_if.field_end !== exp_w.field_end || out_if.line_end !== exp_w.line_end) begin
            n_errors++;
            if (n_errors <= 10)
              $display("%t: word %0d: exp data/has/fe/le=%h/%b/%b/%b got %h/%b/%b/%b",
                       $realtime, n_words_seen, exp_w.data_byte, exp_w.has_byte,
                       exp_w.field_end, exp_w.line_end, out_if.data_byte,
                       out_if.has_byte, out_if.field_end, out_if.line_end);
          end
        end
        // long back-pressure stretch: the sender keeps offering and must stall
        if (n_words_seen == HOLD_AT && !hold_done) begin
          hold_done = 1'b1;
          hold_left = HOLD_LEN;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any accepted word on either side resets the count.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("timeout: %0d cycles without progress, %0d bytes left, %0d words due",
                   quiet_cycles, text_bytes.size(), due_words.size());
          $display("csv_field_splitter_tb failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build stimulus, reset, wait for drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    split_st     = RESET_STATE;
    n_bytes_sent = 0;
    n_words_seen = 0;
    n_field_ends = 0;
    n_line_ends  = 0;
    n_data_bytes = 0;
    n_errors     = 0;
    quiet_cycles = 0;
    hold_done    = 1'b0;

    // Directed part.
    add_byte(CH_QUOTE);              // empty quoted pair closes an empty field
    add_byte(CH_QUOTE);
    add_byte(CH_BSLASH);             // backslash after closing quote: ignored
    add_byte(CH_COMMA);
    add_byte(8'h00);                 // lowest byte as plain data
    add_byte(CH_BSLASH);             // escaped CR kept in an unquoted field
    add_byte(CH_CR);
    add_byte(CH_COMMA);
    add_byte(CH_QUOTE);
    add_byte(CH_BSLASH);             // escaped LF inside quotes
    add_byte(CH_LF);
    add_byte(8'hFF);                 // highest byte inside quotes
    add_byte(CH_QUOTE);
    add_byte(CH_CR);                 // CR after closing quote ends the line
    add_byte(CH_LF);                 // ... and the LF after it is swallowed
    add_byte(CH_CR);                 // line break at field start
    add_byte(CH_CR);                 // second CR is not swallowed
    add_byte(CH_LF);
    add_byte(CH_BSLASH, 1'b1);       // backslash as the final byte
    add_byte(CH_QUOTE);              // unterminated quotes, non-empty at end
    add_byte(8'h41);
    add_byte(8'h42, 1'b1);
    add_byte(CH_QUOTE, 1'b1);        // unterminated and empty at end
    add_byte(8'h78);
    add_byte(CH_LF, 1'b1);           // end of text on a byte that closed the line

    // Random part: well-formed lines with random content, some noise.
    while (text_bytes.size() < 25 + RANDOM_BYTES) add_random_line();
    // make sure the text ends cleanly
    text_bytes[text_bytes.size() - 1].eoi = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // all bytes taken, then all expected words returned
    do @(posedge clk); while (text_bytes.size() != 0 || in_if.valid);
    do @(posedge clk); while (due_words.size() != 0);
    // keep clocking to catch any stray word
    repeat (5) @(posedge clk);

    if (due_words.size() != 0) n_errors += due_words.size();

    $display("sent %0d text bytes, checked %0d result words", n_bytes_sent, n_words_seen);
    $display("(%0d data bytes, %0d field ends, %0d line ends)",
             n_data_bytes, n_field_ends, n_line_ends);
    $display("covered quoting, escapes, CR/LF handling, end-of-text flush, %0d mismatches",
             n_errors);
    if (n_errors == 0) begin
      $display("csv_field_splitter_tb passed");
    end else begin
      $display("csv_field_splitter_tb failed");
    end
    $finish;
  end

endmodule
